[rtl/gdd_pkg.sv]
// Shared types, constants and calendar tables for the date difference block.
// No dependencies; used by gdd_date_num and gregorian_date_difference_top.
`timescale 1ns / 1ps
`default_nettype none
package gdd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int DN_W    = 23;

    // Years above this make a date invalid.
    localparam int MAX_YEAR = 9999;
    localparam int YCMP_W   = 17;

    // floor(u / 25) = (u * RECIP_25) >> RECIP_SHIFT, exact for u < 8192
    localparam int RECIP_25    = 5243;
    localparam int RECIP_SHIFT = 17;
    localparam int DIVIN_W     = 13;
    localparam int QUOT_W      = 9;
    localparam int PROD_W      = DIVIN_W + DIVIN_W;

    localparam int MSTART_W = 9;
    localparam int MOFF_W   = 10;

    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);

    // Enables for the three register stages of one date's day number unit
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

    // Length of a month in a common year; zero for codes that are no month
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the first of the month in a common year
    function automatic logic [MSTART_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic [MSTART_W-1:0] st;
        unique case (m)
            4'd1:    st = 9'd0;
            4'd2:    st = 9'd31;
            4'd3:    st = 9'd59;
            4'd4:    st = 9'd90;
            4'd5:    st = 9'd120;
            4'd6:    st = 9'd151;
            4'd7:    st = 9'd181;
            4'd8:    st = 9'd212;
            4'd9:    st = 9'd243;
            4'd10:   st = 9'd273;
            4'd11:   st = 9'd304;
            4'd12:   st = 9'd334;
            default: st = 9'd0;
        endcase
        return st;
    endfunction

    function automatic logic [QUOT_W-1:0] div25(input logic [DIVIN_W-1:0] u);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(u) * PROD_W'(RECIP_25);
        return prod[RECIP_SHIFT +: QUOT_W];
    endfunction

endpackage
`default_nettype wire

[rtl/gdd_date_num.sv]
// Three-stage validity check and day number for one calendar date.
// Depends on gdd_pkg; stage enables come from the top level pipeline control.
`timescale 1ns / 1ps
`default_nettype none
module gdd_date_num #(
    parameter int MAX_YEAR = gdd_pkg::MAX_YEAR
) (
    input  wire                          i_clk,
    input  gdd_pkg::t_stage_en           i_en,
    input  wire [gdd_pkg::DAY_W-1:0]     i_day,
    input  wire [gdd_pkg::MONTH_W-1:0]   i_month,
    input  wire [gdd_pkg::YEAR_W-1:0]    i_year,
    output logic                         o_ok,
    output logic [gdd_pkg::DN_W-1:0]     o_day_num
);

    localparam int DN_W = gdd_pkg::DN_W;
    localparam int DIVIN_W = gdd_pkg::DIVIN_W;
    localparam int QUOT_W = gdd_pkg::QUOT_W;
    localparam int YEAR_W = gdd_pkg::YEAR_W;

    // stage 1: table lookups, range checks and the constant divisions
    logic [gdd_pkg::DAY_W-1:0]    r_a_day;
    logic [gdd_pkg::DAY_W-1:0]    r_a_len;
    logic [gdd_pkg::MSTART_W-1:0] r_a_start;
    logic [YEAR_W-1:0]            r_a_year;
    logic                         r_a_base_ok;
    logic                         r_a_is_feb;
    logic                         r_a_after_feb;
    logic [QUOT_W-1:0]            r_a_q100c;
    logic [QUOT_W-1:0]            r_a_q400c;
    logic [QUOT_W-1:0]            r_a_q100f;
    logic [QUOT_W-1:0]            r_a_q400f;
    logic [DN_W-1:0]              r_a_y365;

    logic [YEAR_W:0] n_y99;
    logic [YEAR_W:0] n_y399;

    always_comb begin
        n_y99  = (YEAR_W+1)'(i_year) + (YEAR_W+1)'(99);
        n_y399 = (YEAR_W+1)'(i_year) + (YEAR_W+1)'(399);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_a_day       <= i_day;
            r_a_len       <= gdd_pkg::month_len(i_month);
            r_a_start     <= gdd_pkg::month_start(i_month);
            r_a_year      <= i_year;
            r_a_base_ok   <= (gdd_pkg::month_len(i_month) != '0) && (i_day != '0) &&
                             (gdd_pkg::YCMP_W'(i_year) <=
                              gdd_pkg::YCMP_W'(MAX_YEAR));
            r_a_is_feb    <= (i_month == gdd_pkg::MONTH_FEB);
            r_a_after_feb <= (i_month > gdd_pkg::MONTH_FEB);
            // ceil(y/100) = floor(floor((y+99)/4) / 25), ceil(y/400) likewise with 16
            r_a_q100c     <= gdd_pkg::div25(DIVIN_W'(n_y99 >> 2));
            r_a_q400c     <= gdd_pkg::div25(DIVIN_W'(n_y399 >> 4));
            r_a_q100f     <= gdd_pkg::div25(DIVIN_W'(i_year >> 2));
            r_a_q400f     <= gdd_pkg::div25(DIVIN_W'(i_year >> 4));
            r_a_y365      <= DN_W'(i_year) * DN_W'(365);
        end
    end

    // stage 2: leap year, final validity, year part of the day number and month offset
    logic [DIVIN_W-1:0]  n_f100;
    logic [DIVIN_W-1:0]  n_f400;
    logic [DIVIN_W-1:0]  n_ceil4;
    logic                n_leap;
    logic [gdd_pkg::DAY_W:0] n_len;

    always_comb begin
        n_f100  = DIVIN_W'(r_a_year >> 2);
        n_f400  = DIVIN_W'(r_a_year >> 4);
        n_ceil4 = DIVIN_W'(((YEAR_W+1)'(r_a_year) + (YEAR_W+1)'(3)) >> 2);
        // divisible by 4 and not by 100, or divisible by 400
        n_leap  = ((r_a_year[1:0] == 2'b00) &&
                   (n_f100 != DIVIN_W'(r_a_q100f) * DIVIN_W'(25))) ||
                  ((r_a_year[3:0] == 4'b0000) &&
                   (n_f400 == DIVIN_W'(r_a_q400f) * DIVIN_W'(25)));
        n_len   = (gdd_pkg::DAY_W+1)'(r_a_len) +
                  (gdd_pkg::DAY_W+1)'(r_a_is_feb && n_leap);
    end

    logic                         r_b_ok;
    logic [DN_W-1:0]              r_b_ysum;
    logic [gdd_pkg::MOFF_W-1:0]   r_b_moff;
    logic [gdd_pkg::DAY_W-1:0]    r_b_day;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_b_ok   <= r_a_base_ok && ((gdd_pkg::DAY_W+1)'(r_a_day) <= n_len);
            r_b_ysum <= r_a_y365 + DN_W'(n_ceil4) - DN_W'(r_a_q100c) + DN_W'(r_a_q400c);
            r_b_moff <= gdd_pkg::MOFF_W'(r_a_start) +
                        gdd_pkg::MOFF_W'(r_a_after_feb && n_leap);
            r_b_day  <= r_a_day;
        end
    end

    // stage 3: add month and day
    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            o_ok      <= r_b_ok;
            o_day_num <= r_b_ysum + DN_W'(r_b_moff) + DN_W'(r_b_day);
        end
    end

endmodule
`default_nettype wire

[rtl/gregorian_date_difference_top.sv]
// Throughput 1 item per cycle while the output side does not hold it off.
// Stages: lookups and constant divides, leap/validity and year sum, month/day add,
// difference and output register. Each stage holds under backpressure, so an item
// enters whenever the stage ahead of it is free. Synchronous active-low reset
// clears the stage valid bits only; payload registers are not reset.
// Depends on gdd_pkg and gdd_date_num.
`timescale 1ns / 1ps
`default_nettype none
module gregorian_date_difference_top #(
    parameter int MAX_YEAR = gdd_pkg::MAX_YEAR
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire [gdd_pkg::DAY_W-1:0]           i_entry_day,
    input  wire [gdd_pkg::MONTH_W-1:0]         i_entry_month,
    input  wire [gdd_pkg::YEAR_W-1:0]          i_entry_year,
    input  wire [gdd_pkg::DAY_W-1:0]           i_exit_day,
    input  wire [gdd_pkg::MONTH_W-1:0]         i_exit_month,
    input  wire [gdd_pkg::YEAR_W-1:0]          i_exit_year,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic signed [gdd_pkg::DN_W-1:0]    o_day_count,
    output logic                               o_entry_ok,
    output logic                               o_exit_ok
);

    logic [2:0] r_vld;
    logic       r_out_vld;
    logic       n_en_out;
    gdd_pkg::t_stage_en n_en;

    always_comb begin
        n_en_out = !r_out_vld || i_out_ready;
        n_en.s3  = !r_vld[2] || n_en_out;
        n_en.s2  = !r_vld[1] || n_en.s3;
        n_en.s1  = !r_vld[0] || n_en.s2;
        o_in_ready  = n_en.s1;
        o_out_valid = r_out_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (n_en.s1)  r_vld[0]  <= i_in_valid;
            if (n_en.s2)  r_vld[1]  <= r_vld[0];
            if (n_en.s3)  r_vld[2]  <= r_vld[1];
            if (n_en_out) r_out_vld <= r_vld[2];
        end
    end

    logic                     w_entry_ok;
    logic                     w_exit_ok;
    logic [gdd_pkg::DN_W-1:0] w_entry_dn;
    logic [gdd_pkg::DN_W-1:0] w_exit_dn;

    gdd_date_num #(
        .MAX_YEAR (MAX_YEAR)
    ) u_entry (
        .i_clk     (i_clk),
        .i_en      (n_en),
        .i_day     (i_entry_day),
        .i_month   (i_entry_month),
        .i_year    (i_entry_year),
        .o_ok      (w_entry_ok),
        .o_day_num (w_entry_dn)
    );

    gdd_date_num #(
        .MAX_YEAR (MAX_YEAR)
    ) u_exit (
        .i_clk     (i_clk),
        .i_en      (n_en),
        .i_day     (i_exit_day),
        .i_month   (i_exit_month),
        .i_year    (i_exit_year),
        .o_ok      (w_exit_ok),
        .o_day_num (w_exit_dn)
    );

    // difference wraps mod 2^DN_W, matching the result field width
    always_ff @(posedge i_clk) begin
        if (n_en_out) begin
            o_day_count <= (w_entry_ok && w_exit_ok) ? (w_exit_dn - w_entry_dn) : '0;
            o_entry_ok  <= w_entry_ok;
            o_exit_ok   <= w_exit_ok;
        end
    end

endmodule
`default_nettype wire

[sim/gregorian_date_difference_top_tb.sv]
// Self-checking testbench for gregorian_date_difference_top: directed date pairs, then
// random pairs under valid/ready idling and a long output hold-off, checked in order.
// Depends on gdd_pkg (field widths, MAX_YEAR) and the RTL of the block.
`timescale 1ns / 1ps
module gregorian_date_difference_top_tb;

    localparam int  DAY_W    = gdd_pkg::DAY_W;
    localparam int  MONTH_W  = gdd_pkg::MONTH_W;
    localparam int  YEAR_W   = gdd_pkg::YEAR_W;
    localparam int  DN_W     = gdd_pkg::DN_W;
    localparam int  MAX_YEAR = gdd_pkg::MAX_YEAR;

    localparam int  N_DIRECTED    = 21;
    localparam int  ITEMS_PER_RUN = 500;
    localparam int  RX_HOLD_CYCLES = 200;
    localparam int  DRAIN_CYCLES  = 20;
    localparam time TIMEOUT_NS    = 3_000_000;

    typedef struct packed {
        logic [DAY_W-1:0]   d;
        logic [MONTH_W-1:0] m;
        logic [YEAR_W-1:0]  y;
    } t_cal_date;

    typedef struct packed {
        t_cal_date entry;
        t_cal_date depart;
    } t_dates;

    typedef struct packed {
        logic signed [DN_W-1:0] days;
        logic                   entry_ok;
        logic                   exit_ok;
    } t_stay;

    // known = 1: the typed-in result is used instead of the predictor
    typedef struct packed {
        logic [DAY_W-1:0]       e_day;
        logic [MONTH_W-1:0]     e_mon;
        logic [YEAR_W-1:0]      e_yr;
        logic [DAY_W-1:0]       x_day;
        logic [MONTH_W-1:0]     x_mon;
        logic [YEAR_W-1:0]      x_yr;
        logic                   known;
        logic signed [DN_W-1:0] k_days;
        logic                   k_entry_ok;
        logic                   k_exit_ok;
    } t_dir_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   out_ready = 1'b0;
    logic [DAY_W-1:0]       entry_day = '0;
    logic [MONTH_W-1:0]     entry_month = '0;
    logic [YEAR_W-1:0]      entry_year = '0;
    logic [DAY_W-1:0]       exit_day = '0;
    logic [MONTH_W-1:0]     exit_month = '0;
    logic [YEAR_W-1:0]      exit_year = '0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic signed [DN_W-1:0] o_day_count;
    logic                   o_entry_ok;
    logic                   o_exit_ok;

    t_stay stays_due[$];
    int    errors = 0;
    int    send_idle_pct = 30;
    int    recv_idle_pct = 74;
    bit    rx_hold_req = 1'b0;
    int    rx_hold_left = 0;

    int month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    t_dir_row dir_rows[N_DIRECTED] = '{
        '{1, 1, 2000, 1, 1, 2000, 1, 0, 1, 1},
        '{0, 0, 0, 0, 0, 0, 1, 0, 0, 0},
        '{31, 15, 16383, 31, 15, 16383, 1, 0, 0, 0},
        '{1, 1, 0, 31, 12, 9999, 0, 0, 0, 0},
        '{31, 12, 9999, 1, 1, 0, 0, 0, 0, 0},
        '{0, 1, 2020, 1, 1, 2020, 1, 0, 0, 1},
        '{1, 1, 2020, 1, 13, 2020, 1, 0, 1, 0},
        '{1, 1, 10000, 1, 1, 2020, 1, 0, 0, 1},
        '{1, 1, 9999, 31, 12, 9999, 0, 0, 0, 0},
        '{29, 2, 1900, 1, 3, 1900, 1, 0, 0, 1},
        '{29, 2, 2000, 1, 3, 2000, 1, 1, 1, 1},
        '{29, 2, 0, 1, 3, 0, 1, 1, 1, 1},
        '{28, 2, 2023, 1, 3, 2023, 1, 1, 1, 1},
        '{28, 2, 2024, 1, 3, 2024, 1, 2, 1, 1},
        '{31, 12, 2023, 1, 1, 2024, 1, 1, 1, 1},
        '{31, 4, 2021, 1, 5, 2021, 1, 0, 0, 1},
        '{30, 2, 2024, 1, 1, 2024, 1, 0, 0, 1},
        '{1, 3, 2100, 28, 2, 2100, 1, -1, 1, 1},
        '{15, 6, 1999, 15, 6, 2000, 0, 0, 0, 0},
        '{1, 1, 2020, 1, 0, 2020, 1, 0, 1, 0},
        '{31, 12, 1999, 1, 1, 2000, 1, 1, 1, 1}
    };

    gregorian_date_difference_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_entry_day   (entry_day),
        .i_entry_month (entry_month),
        .i_entry_year  (entry_year),
        .i_exit_day    (exit_day),
        .i_exit_month  (exit_month),
        .i_exit_year   (exit_year),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_day_count   (o_day_count),
        .o_entry_ok    (o_entry_ok),
        .o_exit_ok     (o_exit_ok)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- calendar predictor ----------------

    function automatic bit leap_year(logic [YEAR_W-1:0] y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    // 0 for a month code that is no month
    function automatic int month_length(logic [MONTH_W-1:0] m, logic [YEAR_W-1:0] y);
        if (m < 1 || m > 12)
            return 0;
        if (m == 2 && leap_year(y))
            return 29;
        return month_days[int'(m) - 1];
    endfunction

    function automatic bit date_valid(t_cal_date c);
        if (c.y > MAX_YEAR || c.d == 0)
            return 1'b0;
        return int'(c.d) <= month_length(c.m, c.y);
    endfunction

    // Days since a fixed origin 400 years before year 0
    function automatic longint day_serial(t_cal_date c);
        longint b;
        longint n;
        b = longint'(c.y) + 400;
        n = 365 * b + (b + 3) / 4 - (b + 99) / 100 + (b + 399) / 400 + longint'(c.d);
        for (int k = 1; k < int'(c.m); k++)
            n += month_days[k-1];
        if (c.m > 2 && leap_year(c.y))
            n++;
        return n;
    endfunction

    function automatic t_stay predict_stay(t_dates p);
        t_stay  s;
        longint diff;
        s.entry_ok = date_valid(p.entry);
        s.exit_ok  = date_valid(p.depart);
        diff = 0;
        if (s.entry_ok && s.exit_ok)
            diff = day_serial(p.depart) - day_serial(p.entry);
        s.days = diff[DN_W-1:0];
        return s;
    endfunction

    // ---------------- random dates ----------------

    function automatic t_cal_date pick_valid_date();
        t_cal_date c;
        case ($urandom_range(3))
            0: c.y = YEAR_W'($urandom_range(MAX_YEAR));
            1: c.y = YEAR_W'(100 * $urandom_range(99) + $urandom_range(1));
            2: c.y = YEAR_W'(4 * $urandom_range(MAX_YEAR / 4));
            default: c.y = $urandom_range(1) ? YEAR_W'($urandom_range(3))
                                             : YEAR_W'(MAX_YEAR - $urandom_range(3));
        endcase
        c.m = MONTH_W'($urandom_range(12, 1));
        // month ends and first days get extra weight
        case ($urandom_range(3))
            0: c.d = DAY_W'(month_length(c.m, c.y));
            1: c.d = DAY_W'(1);
            default: c.d = DAY_W'($urandom_range(month_length(c.m, c.y), 1));
        endcase
        return c;
    endfunction

    function automatic t_cal_date spoil_date(t_cal_date c);
        int len;
        len = month_length(c.m, c.y);
        case ($urandom_range(3))
            0: c.d = '0;
            1: c.m = $urandom_range(1) ? MONTH_W'(0) : MONTH_W'($urandom_range(15, 13));
            2: c.y = YEAR_W'($urandom_range((1 << YEAR_W) - 1, MAX_YEAR + 1));
            default: c.d = (len < 31) ? DAY_W'($urandom_range(31, len + 1)) : DAY_W'(0);
        endcase
        return c;
    endfunction

    function automatic t_dates pick_dates();
        t_dates      p;
        int          ny;
        int          r;
        logic [63:0] raw;
        p.entry = pick_valid_date();
        p.depart = pick_valid_date();
        // short stays: exit year within one year of the entry year, either direction
        if ($urandom_range(1)) begin
            ny = int'(p.entry.y) + int'($urandom_range(2)) - 1;
            if (ny < 0)
                ny = 0;
            if (ny > MAX_YEAR)
                ny = MAX_YEAR;
            p.depart.y = YEAR_W'(ny);
            if (p.depart.d > month_length(p.depart.m, p.depart.y))
                p.depart.d = DAY_W'(month_length(p.depart.m, p.depart.y));
        end
        r = $urandom_range(99);
        if (r < 8) begin
            p.entry = spoil_date(p.entry);
        end else if (r < 16) begin
            p.depart = spoil_date(p.depart);
        end else if (r < 20) begin
            p.entry = spoil_date(p.entry);
            p.depart = spoil_date(p.depart);
        end else if (r < 24) begin
            raw = {$urandom, $urandom};
            p = raw[$bits(t_dates)-1:0];
        end
        return p;
    endfunction

    // ---------------- driving ----------------

    task automatic offer_dates(input t_dates p, input t_stay want);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        entry_day   <= p.entry.d;
        entry_month <= p.entry.m;
        entry_year  <= p.entry.y;
        exit_day    <= p.depart.d;
        exit_month  <= p.depart.m;
        exit_year   <= p.depart.y;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        stays_due.push_back(want);
    endtask

    task automatic drain_stays();
        in_valid <= 1'b0;
        wait (stays_due.size() == 0);
        @(posedge i_clk);
    endtask

    // Output ready, with a long hold-off on request counted here
    always @(posedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------- checking ----------------

    always @(posedge i_clk) begin
        t_stay want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (stays_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, got count %0d ok %b/%b",
                         $time, o_day_count, o_entry_ok, o_exit_ok);
            end else begin
                want = stays_due.pop_front();
                if (o_day_count !== want.days) begin
                    errors++;
                    $display("%0t: day_count mismatch: expected %0d, got %0d",
                             $time, want.days, o_day_count);
                end
                if (o_entry_ok !== want.entry_ok) begin
                    errors++;
                    $display("%0t: entry_ok mismatch: expected %b, got %b",
                             $time, want.entry_ok, o_entry_ok);
                end
                if (o_exit_ok !== want.exit_ok) begin
                    errors++;
                    $display("%0t: exit_ok mismatch: expected %b, got %b",
                             $time, want.exit_ok, o_exit_ok);
                end
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        t_dates p;
        t_stay  want;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            p = {dir_rows[i].e_day, dir_rows[i].e_mon, dir_rows[i].e_yr,
                 dir_rows[i].x_day, dir_rows[i].x_mon, dir_rows[i].x_yr};
            if (dir_rows[i].known)
                want = {dir_rows[i].k_days, dir_rows[i].k_entry_ok, dir_rows[i].k_exit_ok};
            else
                want = predict_stay(p);
            offer_dates(p, want);
        end
        drain_stays();

        // sender 30 / receiver 74, then swapped, then no idling with one long hold-off
        for (int run = 0; run < 3; run++) begin
            case (run)
                0: begin send_idle_pct = 30; recv_idle_pct = 74; end
                1: begin send_idle_pct = 74; recv_idle_pct = 30; end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    rx_hold_req = 1'b1;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_RUN; n++) begin
                p = pick_dates();
                offer_dates(p, predict_stay(p));
            end
            drain_stays();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/gdd_pkg.sv
rtl/gdd_date_num.sv
rtl/gregorian_date_difference_top.sv
sim/gregorian_date_difference_top_tb.sv
